FILE: rtl/u2i_pkg.sv
// Shared types, constants and the code point mapping for the UTF-8 to ISO-8859-15 converter.
package u2i_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_CW    = FIFO_AW + 1;

  localparam logic [31:0] CP_LIMIT  = 32'h0010_FFFF;
  localparam logic [7:0]  CH_BSLASH = 8'h5C;
  localparam logic [7:0]  CH_QUOTE  = 8'h22;
  localparam logic [7:0]  CH_QMARK  = 8'h3F;
  localparam logic [7:0]  CH_NUL    = 8'h00;

  // bit positions in a job's piece mask; emitted from high to low
  localparam int unsigned PC_ESC  = 2;
  localparam int unsigned PC_CHR  = 1;
  localparam int unsigned PC_TERM = 0;

  typedef struct packed {
    logic [2:0] pieces;
    logic [7:0] char_byte;
  } u2i_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } u2i_fifo_stat_t;

  function automatic logic [7:0] to_iso(input logic [31:0] cp);
    logic [7:0] res;
    res = CH_QMARK;
    if (cp[31:8] == 24'h0) begin
      unique case (cp[7:0]) inside
        8'hA4, 8'hA6, 8'hA8, 8'hB4, 8'hB8, 8'hBC, 8'hBD, 8'hBE: res = CH_QMARK;
        default: res = cp[7:0];
      endcase
    end else begin
      unique case (cp)
        32'h0000_20AC: res = 8'hA4;
        32'h0000_0160: res = 8'hA6;
        32'h0000_0161: res = 8'hA8;
        32'h0000_017D: res = 8'hB4;
        32'h0000_017E: res = 8'hB8;
        32'h0000_0152: res = 8'hBC;
        32'h0000_0153: res = 8'hBD;
        32'h0000_0178: res = 8'hBE;
        default:       res = CH_QMARK;
      endcase
    end
    return res;
  endfunction

endpackage

FILE: rtl/u2i_front.sv
// Front end: takes input bytes, tracks the code point and builds output jobs.
module u2i_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte,
  input  logic              fifo_full,
  output logic              job_push,
  output u2i_pkg::u2i_job_t job
);
  import u2i_pkg::*;

  logic [31:0] accum_r, accum_nxt;
  logic        pending_r, pending_nxt;
  logic        accept, is_cont, emit, is_term, need_esc;
  logic [7:0]  iso_byte;

  assign in_stall = fifo_full;
  assign accept   = in_valid && !fifo_full;
  assign is_cont  = (in_byte[7:6] == 2'b10);
  assign is_term  = (in_byte == CH_NUL);
  assign iso_byte = to_iso(accum_r);
  assign emit     = pending_r && !is_cont && (accum_r <= CP_LIMIT);
  assign need_esc = emit && ((iso_byte == CH_QUOTE) || (iso_byte == CH_BSLASH));

  always_comb begin
    job.pieces          = '0;
    job.pieces[PC_ESC]  = need_esc;
    job.pieces[PC_CHR]  = emit;
    job.pieces[PC_TERM] = is_term;
    job.char_byte       = iso_byte;
  end

  // bytes that produce nothing are not queued
  assign job_push = accept && (emit || is_term);

  always_comb begin
    accum_nxt   = accum_r;
    pending_nxt = pending_r;
    if (accept) begin
      if (is_term) begin
        accum_nxt   = '0;
        pending_nxt = 1'b0;
      end else begin
        pending_nxt = 1'b1;
        if (!in_byte[7])          accum_nxt = {24'h0, in_byte};
        else if (!in_byte[6])     accum_nxt = {accum_r[25:0], in_byte[5:0]};
        else if (!in_byte[5])     accum_nxt = {27'h0, in_byte[4:0]};
        else if (!in_byte[4])     accum_nxt = {28'h0, in_byte[3:0]};
        else                      accum_nxt = {29'h0, in_byte[2:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r   <= '0;
      pending_r <= 1'b0;
    end else begin
      accum_r   <= accum_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule

FILE: rtl/u2i_fifo.sv
// Small job queue between the front end and the output sequencer.
module u2i_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  u2i_pkg::u2i_job_t       wr_job,
  input  logic                    pop,
  output u2i_pkg::u2i_job_t       head,
  output u2i_pkg::u2i_fifo_stat_t stat
);
  import u2i_pkg::*;

  u2i_job_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0]   cnt_r, cnt_nxt;

  assign head       = mem[rd_ptr_r];
  assign stat.full  = (cnt_r == FIFO_CW'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/u2i_back.sv
// Back end: walks each queued job and drives one output byte per transfer.
module u2i_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  u2i_pkg::u2i_job_t       head,
  input  u2i_pkg::u2i_fifo_stat_t stat,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_byte,
  output logic                    out_run_last
);
  import u2i_pkg::*;

  logic [2:0] done_r, done_nxt;
  logic [2:0] pend, sel;
  logic       load, last;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_last = out_last_r;

  assign pend = head.pieces & ~done_r;
  assign load = !stat.empty && (!out_valid_r || !out_stall);

  always_comb begin
    sel          = '0;
    out_byte_nxt = out_byte_r;
    if (pend[PC_ESC]) begin
      sel[PC_ESC]  = 1'b1;
      out_byte_nxt = CH_BSLASH;
    end else if (pend[PC_CHR]) begin
      sel[PC_CHR]  = 1'b1;
      out_byte_nxt = head.char_byte;
    end else begin
      sel[PC_TERM] = 1'b1;
      out_byte_nxt = CH_NUL;
    end
    last = ((pend & ~sel) == '0);

    pop           = load && last;
    done_nxt      = done_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = last;
      done_nxt      = last ? '0 : (done_r | sel);
    end else begin
      out_byte_nxt = out_byte_r;
      if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/utf8_to_iso8859_15_converter_top.sv
// Top level of the UTF-8 to ISO-8859-15 stream converter.
//
// Input channel: one UTF-8 byte per transfer on in_byte (in_valid/in_stall).
// A zero byte ends a string: any pending character is flushed, a zero
// terminator follows and the decoder state is cleared.
// Output channel: one ISO-8859-15 byte per transfer on out_byte, with
// out_run_last set on the last byte caused by an input byte. A quote or
// backslash character is preceded by a backslash byte.
// A character comes out when the next non-continuation byte arrives.
// A job passes through the queue and then the output register to out_valid.
// Throughput: one input byte per cycle while each byte produces at most one
// output byte and the receiver does not stall; the output side sends one
// byte per cycle unless stalled, so an escape or a terminator each adds an
// output byte. A four-entry job queue sits between the decoder and the
// output sequencer; in_stall is high only while that queue is full.
// When the receiver stalls, the output register holds its byte and the queue
// fills, after which the input is stalled.
// Reset (rst_n low, synchronous) clears the decoder, the queue and out_valid.
module utf8_to_iso8859_15_converter_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last
);
  import u2i_pkg::*;

  u2i_job_t       push_job, head_job;
  u2i_fifo_stat_t fifo_stat;
  logic           job_push, job_pop;

  u2i_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .fifo_full (fifo_stat.full),
    .job_push  (job_push),
    .job       (push_job)
  );

  u2i_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (job_push),
    .wr_job (push_job),
    .pop    (job_pop),
    .head   (head_job),
    .stat   (fifo_stat)
  );

  u2i_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head_job),
    .stat         (fifo_stat),
    .pop          (job_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(job_push && fifo_stat.full))
    else $error("job pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(job_pop && fifo_stat.empty))
    else $error("job popped from an empty queue");

  // the rest of a job follows right after a non-final transfer
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_run_last) |=> out_valid)
    else $error("output run broken before its last byte");

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the UTF-8 to ISO-8859-15 stream converter.
module tb;
  import u2i_pkg::CP_LIMIT;
  import u2i_pkg::CH_BSLASH;
  import u2i_pkg::CH_QUOTE;
  import u2i_pkg::CH_QMARK;
  import u2i_pkg::CH_NUL;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } iso_out_t;

  // Tracks the decoder state and the ISO bytes still owed by the block.
  class xlat_scoreboard;
    logic [31:0] code_acc;
    bit          char_open;
    iso_out_t    iso_expect_q[$];
    int          errors;

    function new();
      code_acc  = '0;
      char_open = 1'b0;
      errors    = 0;
    endfunction

    function logic [7:0] iso_of_code(logic [31:0] cp);
      logic [7:0] r;
      r = CH_QMARK;
      if (cp[31:8] == 24'h0) begin
        case (cp[7:0])
          8'hA4, 8'hA6, 8'hA8, 8'hB4, 8'hB8, 8'hBC, 8'hBD, 8'hBE: r = CH_QMARK;
          default: r = cp[7:0];
        endcase
      end else begin
        case (cp)
          32'h20AC: r = 8'hA4;
          32'h0160: r = 8'hA6;
          32'h0161: r = 8'hA8;
          32'h017D: r = 8'hB4;
          32'h017E: r = 8'hB8;
          32'h0152: r = 8'hBC;
          32'h0153: r = 8'hBD;
          32'h0178: r = 8'hBE;
          default:  r = CH_QMARK;
        endcase
      end
      return r;
    endfunction

    function void note_byte(logic [7:0] b);
      iso_out_t   outs[$];
      logic [7:0] c;
      // a non-continuation byte resolves the pending character first
      if (char_open && b[7:6] != 2'b10 && code_acc <= CP_LIMIT) begin
        c = iso_of_code(code_acc);
        if (c == CH_QUOTE || c == CH_BSLASH) outs.push_back(iso_out_t'{CH_BSLASH, 1'b0});
        outs.push_back(iso_out_t'{c, 1'b0});
      end
      if (b == CH_NUL) begin
        outs.push_back(iso_out_t'{CH_NUL, 1'b0});
        code_acc  = '0;
        char_open = 1'b0;
      end else begin
        if (b <= 8'h7F)      code_acc = {24'h0, b};
        else if (b <= 8'hBF) code_acc = {code_acc[25:0], b[5:0]};
        else if (b <= 8'hDF) code_acc = {27'h0, b[4:0]};
        else if (b <= 8'hEF) code_acc = {28'h0, b[3:0]};
        else                 code_acc = {29'h0, b[2:0]};
        char_open = 1'b1;
      end
      if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
      foreach (outs[i]) iso_expect_q.push_back(outs[i]);
    endfunction

    function void check_result(logic [7:0] ch, logic last);
      iso_out_t want;
      if (iso_expect_q.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, got out_byte %02h run_last %0b",
                 $time, ch, last);
        errors++;
        return;
      end
      want = iso_expect_q.pop_front();
      if (ch !== want.ch) begin
        $display("%0t: out_byte expected %02h got %02h", $time, want.ch, ch);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: out_run_last expected %0b got %0b", $time, want.last, last);
        errors++;
      end
    endfunction

    function int outstanding();
      return iso_expect_q.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_run_last;

  xlat_scoreboard sb = new();
  int send_idle_pct;
  int recv_idle_pct;
  int bytes_sent;

  // empty string, escapes, multi-byte forms, replaced slots, limit, too large,
  // stray continuation, all-ones lead
  logic [7:0] dir_seq [25] = '{
    8'h00, 8'h22, 8'h5C, 8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hC2,
    8'hA4, 8'hC5, 8'hB8, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hF7, 8'hBF, 8'hBF,
    8'hBF, 8'h80, 8'h00, 8'hFF, 8'h00
  };

  utf8_to_iso8859_15_converter_top DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_byte, out_run_last);
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // encode cp as UTF-8 and send it, leaving off the last 'drop' bytes
  task automatic send_cp(logic [31:0] cp, int drop);
    logic [7:0] seq[$];
    int         n;
    if (cp < 32'h80)
      seq = '{cp[7:0]};
    else if (cp < 32'h800)
      seq = '{{3'b110, cp[10:6]}, {2'b10, cp[5:0]}};
    else if (cp < 32'h10000)
      seq = '{{4'b1110, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
    else
      seq = '{{5'b11110, cp[20:18]}, {2'b10, cp[17:12]}, {2'b10, cp[11:6]},
              {2'b10, cp[5:0]}};
    n = seq.size() - drop;
    if (n < 1) n = 1;
    for (int i = 0; i < n; i++) send_byte(seq[i]);
  endtask

  task automatic drain_output();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic random_bytes(int target);
    int          pick;
    logic [31:0] cp;
    logic [31:0] special [16];
    special = '{32'h20AC, 32'h0160, 32'h0161, 32'h017D, 32'h017E, 32'h0152, 32'h0153,
                32'h0178, 32'hA4, 32'hA6, 32'hA8, 32'hB4, 32'hB8, 32'hBC, 32'hBD, 32'hBE};
    bytes_sent = 0;
    while (bytes_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        if ($urandom_range(3) == 0) cp = {24'h0, ($urandom_range(1) ? CH_QUOTE : CH_BSLASH)};
        else cp = $urandom_range(32'h7F, 1);
        send_cp(cp, 0);
      end else if (pick < 40) send_cp($urandom_range(32'h7FF, 32'h80), 0);
      else if (pick < 50) send_cp($urandom_range(32'hFFFF, 32'h800), 0);
      else if (pick < 55) send_cp($urandom_range(32'h10FFFF, 32'h10000), 0);
      else if (pick < 58) send_cp($urandom_range(32'h1FFFFF, 32'h110000), 0);
      else if (pick < 74) send_cp(special[$urandom_range(15)], 0);
      else if (pick < 82) send_byte(CH_NUL);
      else if (pick < 88) send_cp($urandom_range(32'h10FFFF, 32'h800), $urandom_range(2, 1));
      else send_byte(8'($urandom_range(255)));
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_byte       <= 8'h00;
    send_idle_pct = 31;
    recv_idle_pct = 63;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_seq[i]) send_byte(dir_seq[i]);
    random_bytes(70);
    drain_output();

    send_idle_pct = 63;
    recv_idle_pct = 31;
    random_bytes(70);
    drain_output();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_bytes(64);
    send_byte(CH_NUL);
    drain_output();
    repeat (8) @(posedge clk);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

FILE: files.f
rtl/u2i_pkg.sv
rtl/u2i_front.sv
rtl/u2i_fifo.sv
rtl/u2i_back.sv
rtl/utf8_to_iso8859_15_converter_top.sv
tb/sv/tb.sv
